[hw/rtl/jsesc_pkg.sv]
// Package for the JSON string escaper with UTF-8 checking.
// Holds the transaction structs, the work descriptor passed from front to back,
// and shared constants. No dependencies.
package jsesc_pkg;

  localparam int unsigned FifoDepthDefault = 4;

  localparam logic [7:0] QuoteChar = 8'h22;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       empty_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_done;
    logic       string_valid;
  } out_item_t;

  typedef enum logic [1:0] {
    MainNone,
    MainAscii,
    MainRaw
  } main_kind_e;

  // Everything one input transaction emits, in order: opening quote,
  // replacement characters, one escaped ASCII byte or a passed sequence,
  // replacement characters for held bytes at the end, closing quote.
  typedef struct packed {
    logic            open_quote;
    logic [2:0]      pre_repl;
    main_kind_e      main_kind;
    logic [1:0]      raw_last;
    logic [3:0][7:0] raw;
    logic [2:0]      post_repl;
    logic            close_quote;
    logic            valid;
  } desc_t;

  function automatic logic desc_empty(input desc_t d);
    return !d.open_quote && (d.pre_repl == 3'd0) && (d.main_kind == MainNone) &&
           (d.post_repl == 3'd0) && !d.close_quote;
  endfunction

endpackage

[hw/rtl/jsesc_front.sv]
// Front part: accepts input transactions, tracks pending UTF-8 bytes and
// validates sequences, and pushes at most one work descriptor per transaction.
// Depends on jsesc_pkg.
module jsesc_front import jsesc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_i,
  input  logic     full_i,
  output logic     push_o,
  output desc_t    desc_o
);

  localparam logic [20:0] CpMax     = 21'h10FFFF;
  localparam logic [20:0] SurrLow   = 21'h00D800;
  localparam logic [20:0] SurrHigh  = 21'h00DFFF;
  localparam logic [20:0] Min2      = 21'h000080;
  localparam logic [20:0] Min3      = 21'h000800;
  localparam logic [20:0] Min4      = 21'h010000;

  logic [2:0][7:0] pend_q, pend_d;
  logic [1:0]      pcnt_q, pcnt_d;
  logic [2:0]      elen_q, elen_d;
  logic            ok_q, ok_d;
  logic            accept;
  logic [20:0]     cp;
  logic [20:0]     cp_min;
  logic            cp_ok;
  desc_t           desc;

  function automatic logic [2:0] utf8_seq_len(input logic [7:0] b);
    logic [2:0] n;
    n = 3'd0;
    if (b[7:5] == 3'b110) begin
      n = 3'd2;
    end else if (b[7:4] == 4'b1110) begin
      n = 3'd3;
    end else if (b[7:3] == 5'b11110) begin
      n = 3'd4;
    end
    return n;
  endfunction

  assign accept     = in_valid_i && !full_i;
  assign in_ready_o = !full_i;
  assign push_o     = accept && !desc_empty(desc);
  assign desc_o     = desc;

  always_comb begin
    cp     = '0;
    cp_min = Min2;
    unique case (elen_q)
      3'd2: begin
        cp     = {10'd0, pend_q[0][4:0], in_i.data_byte[5:0]};
        cp_min = Min2;
      end
      3'd3: begin
        cp     = {5'd0, pend_q[0][3:0], pend_q[1][5:0], in_i.data_byte[5:0]};
        cp_min = Min3;
      end
      3'd4: begin
        cp     = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], in_i.data_byte[5:0]};
        cp_min = Min4;
      end
      default: begin
        cp     = '0;
        cp_min = CpMax;
      end
    endcase
    cp_ok = (elen_q >= 3'd2) && (elen_q <= 3'd4) && (cp <= CpMax) && (cp >= cp_min) &&
            !((cp >= SurrLow) && (cp <= SurrHigh));
  end

  always_comb begin
    logic [2:0][7:0] pb;
    logic [1:0]      pc;
    logic [2:0]      el;
    logic            ok;
    logic            start;
    logic [7:0]      b;
    logic [2:0]      n;

    desc           = '0;
    desc.main_kind = MainNone;
    pend_d         = pend_q;
    pcnt_d         = pcnt_q;
    elen_d         = elen_q;
    ok_d           = ok_q;
    b              = in_i.data_byte;
    n              = utf8_seq_len(b);
    pb             = pend_q;
    pc             = pcnt_q;
    el             = elen_q;
    ok             = ok_q;
    start          = 1'b0;

    if (in_i.empty_string) begin
      desc.open_quote  = 1'b1;
      desc.close_quote = 1'b1;
      desc.valid       = 1'b1;
      pend_d           = '0;
      pcnt_d           = 2'd0;
      elen_d           = 3'd0;
      ok_d             = 1'b1;
    end else begin
      if (in_i.first_byte) begin
        pb              = '0;
        pc              = 2'd0;
        el              = 3'd0;
        ok              = 1'b1;
        desc.open_quote = 1'b1;
      end

      if (pc == 2'd0) begin
        start = 1'b1;
      end else if (b[7:6] != 2'b10) begin
        desc.pre_repl = {1'b0, pc};
        ok            = 1'b0;
        pb            = '0;
        pc            = 2'd0;
        el            = 3'd0;
        start         = 1'b1;
      end else if (({1'b0, pc} + 3'd1) < el) begin
        for (int i = 0; i < 3; i++) begin
          if (pc == 2'(i)) begin
            pb[i] = b;
          end
        end
        pc = pc + 2'd1;
      end else begin
        if (cp_ok) begin
          desc.main_kind = MainRaw;
          desc.raw       = {8'h00, pb[2], pb[1], pb[0]};
          desc.raw[pc]   = b;
          desc.raw_last  = pc;
        end else begin
          desc.pre_repl = {1'b0, pc} + 3'd1;
          ok            = 1'b0;
        end
        pb = '0;
        pc = 2'd0;
        el = 3'd0;
      end

      if (start) begin
        if (!b[7]) begin
          desc.main_kind = MainAscii;
          desc.raw[0]    = b;
        end else if (n == 3'd0) begin
          desc.pre_repl = desc.pre_repl + 3'd1;
          ok            = 1'b0;
        end else begin
          pb[0] = b;
          pc    = 2'd1;
          el    = n;
        end
      end

      if (in_i.last_byte) begin
        desc.post_repl = {1'b0, pc};
        if (pc != 2'd0) begin
          ok = 1'b0;
        end
        desc.close_quote = 1'b1;
        desc.valid       = ok;
        pend_d           = '0;
        pcnt_d           = 2'd0;
        elen_d           = 3'd0;
        ok_d             = 1'b1;
      end else begin
        pend_d = pb;
        pcnt_d = pc;
        elen_d = el;
        ok_d   = ok;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pcnt_q <= 2'd0;
      elen_q <= 3'd0;
      ok_q   <= 1'b1;
    end else if (accept) begin
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
      elen_q <= elen_d;
      ok_q   <= ok_d;
    end
  end

  a_pending_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pcnt_q != 2'd0) |-> (elen_q >= 3'd2 && elen_q <= 3'd4 && {1'b0, pcnt_q} < elen_q))
    else $error("pending count inconsistent with expected length");

  a_idle_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pcnt_q == 2'd0) |-> (elen_q == 3'd0))
    else $error("expected length set with no pending bytes");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.last_byte || in_i.empty_string)) |=> (pcnt_q == 2'd0 && ok_q))
    else $error("state not returned to reset after a closing quote");

endmodule

[hw/rtl/jsesc_fifo.sv]
// Short descriptor queue between the front and back parts.
// Depends on jsesc_pkg for desc_t.
module jsesc_fifo import jsesc_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  desc_t push_data_i,
  output logic  full_o,
  input  logic  pop_i,
  output desc_t pop_data_o,
  output logic  empty_o
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CW = $clog2(Depth + 1);

  desc_t          mem_q [Depth];
  logic [AW-1:0]  wptr_q, wptr_d;
  logic [AW-1:0]  rptr_q, rptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == CW'(Depth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + AW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("pop from an empty queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(Depth))
    else $error("queue count exceeds depth");

endmodule

[hw/rtl/jsesc_back.sv]
// Back part: expands work descriptors into output bytes, one per cycle while the
// output is accepted, through a registered output stage. Depends on jsesc_pkg.
module jsesc_back import jsesc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  desc_t     desc_i,
  input  logic      desc_valid_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o
);

  desc_t      cur_q;
  logic       busy_q;
  logic [2:0] idx_q;
  logic       out_valid_q;
  out_item_t  out_q;

  desc_t      work;
  desc_t      nxt;
  logic [2:0] idx;
  logic [2:0] idx_n;
  logic       have;
  logic       advance;
  out_item_t  item;

  function automatic logic [7:0] esc_code(input logic [7:0] c);
    logic [7:0] e;
    unique case (c)
      8'h22:   e = 8'h22;
      8'h5C:   e = 8'h5C;
      8'h08:   e = 8'h62;
      8'h0C:   e = 8'h66;
      8'h0A:   e = 8'h6E;
      8'h0D:   e = 8'h72;
      8'h09:   e = 8'h74;
      default: e = 8'h00;
    endcase
    return e;
  endfunction

  function automatic logic [2:0] ascii_len(input logic [7:0] c);
    logic [2:0] n;
    if (esc_code(c) != 8'h00) begin
      n = 3'd2;
    end else if (c < 8'h20) begin
      n = 3'd6;
    end else begin
      n = 3'd1;
    end
    return n;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? ({4'h0, v} + 8'h30) : ({4'h0, v} + 8'h57);
  endfunction

  function automatic logic [7:0] ascii_byte(input logic [7:0] c, input logic [2:0] i);
    logic [7:0] e;
    logic [7:0] r;
    e = esc_code(c);
    if (e != 8'h00) begin
      r = (i == 3'd0) ? 8'h5C : e;
    end else if (c < 8'h20) begin
      unique case (i)
        3'd0:    r = 8'h5C;
        3'd1:    r = 8'h75;
        3'd4:    r = hex_char(c[7:4]);
        3'd5:    r = hex_char(c[3:0]);
        default: r = 8'h30;
      endcase
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic [7:0] repl_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = 8'hEF;
      3'd1:    r = 8'hBF;
      default: r = 8'hBD;
    endcase
    return r;
  endfunction

  assign work    = busy_q ? cur_q : desc_i;
  assign idx     = busy_q ? idx_q : 3'd0;
  assign have    = busy_q || desc_valid_i;
  assign advance = !out_valid_q || out_ready_i;
  assign pop_o   = advance && desc_valid_i && !busy_q;

  always_comb begin
    nxt               = work;
    idx_n             = idx;
    item              = '0;
    if (work.open_quote) begin
      item.out_byte   = QuoteChar;
      nxt.open_quote  = 1'b0;
    end else if (work.pre_repl != 3'd0) begin
      item.out_byte   = repl_byte(idx);
      if (idx == 3'd2) begin
        idx_n         = 3'd0;
        nxt.pre_repl  = work.pre_repl - 3'd1;
      end else begin
        idx_n         = idx + 3'd1;
      end
    end else if (work.main_kind == MainAscii) begin
      item.out_byte   = ascii_byte(work.raw[0], idx);
      if (idx == ascii_len(work.raw[0]) - 3'd1) begin
        idx_n         = 3'd0;
        nxt.main_kind = MainNone;
      end else begin
        idx_n         = idx + 3'd1;
      end
    end else if (work.main_kind == MainRaw) begin
      item.out_byte   = work.raw[idx[1:0]];
      if (idx[1:0] == work.raw_last) begin
        idx_n         = 3'd0;
        nxt.main_kind = MainNone;
      end else begin
        idx_n         = idx + 3'd1;
      end
    end else if (work.post_repl != 3'd0) begin
      item.out_byte   = repl_byte(idx);
      if (idx == 3'd2) begin
        idx_n         = 3'd0;
        nxt.post_repl = work.post_repl - 3'd1;
      end else begin
        idx_n         = idx + 3'd1;
      end
    end else begin
      item.out_byte     = QuoteChar;
      item.string_done  = 1'b1;
      item.string_valid = work.valid;
      nxt.close_quote   = 1'b0;
    end
    item.run_last = desc_empty(nxt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= have;
      if (have) begin
        busy_q <= !item.run_last;
        idx_q  <= idx_n;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && have) begin
      cur_q <= nxt;
      out_q <= item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_done_is_quote: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.string_done) |-> (out_q.run_last && out_q.out_byte == QuoteChar))
    else $error("closing quote not last or wrong byte");

  a_valid_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.string_valid) |-> out_q.string_done)
    else $error("string_valid without string_done");

  a_busy_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (out_valid_q && !out_q.run_last))
    else $error("back busy without an unfinished transaction in flight");

endmodule

[hw/rtl/json_string_escape_utf8_check.sv]
// With the queue and back part idle, an accepted transaction's descriptor is written into
// the queue and then registered into the output stage.
// Throughput: the back part emits one byte per cycle while work is queued and the output is
// accepted, and a transaction makes 0 to 16 bytes; input transactions are taken one per cycle
// while the FifoDepth-entry descriptor queue has room, and one with no output bytes is not queued.
// Reset clears pending UTF-8 bytes, sets the string-valid flag and empties queue and output.
module json_string_escape_utf8_check import jsesc_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_o
);

  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  desc_t push_desc;
  desc_t head_desc;

  jsesc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .full_i     (full),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  jsesc_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head_desc),
    .empty_o     (empty)
  );

  jsesc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_i       (head_desc),
    .desc_valid_i (!empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_o        (out_o)
  );

endmodule

[bench/tb.sv]
// Self-checking testbench for the JSON string escaper with UTF-8 checking.
// Predicts every literal byte from the raw string bytes and compares the output stream.
// Depends on jsesc_pkg and json_string_escape_utf8_check.
`timescale 1ns / 100ps

module tb;
  import jsesc_pkg::*;

  localparam int unsigned MaxLitBytes = 16;
  localparam int unsigned RandomItems = 138;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned HoldCycles = 400;
  localparam logic [7:0] BackslashChar = 8'h5C;
  localparam logic [7:0] LetterU = 8'h75;
  localparam logic [7:0] DigitZero = 8'h30;

  typedef struct {
    in_item_t item;
    bit       drain;
  } feed_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_o;
  logic      rx_hold = 1'b0;

  feed_t       feed_q[$];
  out_item_t   json_out_q[$];
  logic [7:0]  str_q[$];
  logic [7:0]  lit_q[$];

  logic [7:0]  held_bytes[3];
  int unsigned held_n = 0;
  int unsigned seq_len = 0;
  bit          str_ok = 1'b1;

  int unsigned n_accepted = 0;
  int unsigned n_errors = 0;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  int unsigned rx_tick = 0;

  json_string_escape_utf8_check DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic put_byte(input logic [7:0] b);
    if (lit_q.size() < MaxLitBytes) lit_q.insert(lit_q.size(), b);
  endtask

  task automatic add_raw(input logic [7:0] b);
    str_q.insert(str_q.size(), b);
  endtask

  task automatic put_repl();
    put_byte(8'hEF);
    put_byte(8'hBF);
    put_byte(8'hBD);
    str_ok = 1'b0;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    return (v < 4'd10) ? DigitZero + 8'(v) : 8'h61 + 8'(v) - 8'd10;
  endfunction

  task automatic put_ascii(input logic [7:0] c);
    logic [7:0] esc;
    esc = 8'h00;
    case (c)
      QuoteChar:     esc = QuoteChar;
      BackslashChar: esc = BackslashChar;
      8'h08:         esc = 8'h62;
      8'h0C:         esc = 8'h66;
      8'h0A:         esc = 8'h6E;
      8'h0D:         esc = 8'h72;
      8'h09:         esc = 8'h74;
      default:       esc = 8'h00;
    endcase
    if (esc != 8'h00) begin
      put_byte(BackslashChar);
      put_byte(esc);
    end else if (c < 8'h20) begin
      put_byte(BackslashChar);
      put_byte(LetterU);
      put_byte(DigitZero);
      put_byte(DigitZero);
      put_byte(hex_char(c[7:4]));
      put_byte(hex_char(c[3:0]));
    end else begin
      put_byte(c);
    end
  endtask

  function automatic int unsigned utf8_seq_len(input logic [7:0] b);
    if (b < 8'h80) return 1;
    if (b[7:5] == 3'b110) return 2;
    if (b[7:4] == 4'b1110) return 3;
    if (b[7:3] == 5'b11110) return 4;
    return 0;
  endfunction

  task automatic drop_held();
    held_n = 0;
    seq_len = 0;
    held_bytes = '{default: 8'h00};
  endtask

  task automatic flush_held();
    for (int unsigned i = 0; i < held_n; i++) put_repl();
    drop_held();
  endtask

  task automatic start_seq(input logic [7:0] b);
    int unsigned n;
    if (b < 8'h80) begin
      put_ascii(b);
    end else begin
      n = utf8_seq_len(b);
      if (n == 0) begin
        put_repl();
      end else begin
        held_bytes[0] = b;
        held_n = 1;
        seq_len = n;
      end
    end
  endtask

  task automatic feed_byte(input logic [7:0] b);
    int unsigned cp;
    int unsigned min_cp;
    bit ok;
    if (held_n == 0) begin
      start_seq(b);
    end else if (b[7:6] != 2'b10) begin
      flush_held();
      start_seq(b);
    end else if (held_n + 1 < seq_len) begin
      held_bytes[held_n] = b;
      held_n++;
    end else begin
      case (seq_len)
        2:       begin cp = 32'(held_bytes[0] & 8'h1F); min_cp = 'h80; end
        3:       begin cp = 32'(held_bytes[0] & 8'h0F); min_cp = 'h800; end
        default: begin cp = 32'(held_bytes[0] & 8'h07); min_cp = 'h10000; end
      endcase
      for (int unsigned i = 1; i < held_n; i++) cp = (cp << 6) | 32'(held_bytes[i][5:0]);
      cp = (cp << 6) | 32'(b[5:0]);
      ok = (cp <= 'h10FFFF) && !(cp >= 'hD800 && cp <= 'hDFFF) && (cp >= min_cp);
      if (ok) begin
        for (int unsigned i = 0; i < held_n; i++) put_byte(held_bytes[i]);
        put_byte(b);
      end else begin
        for (int unsigned i = 0; i <= held_n; i++) put_repl();
      end
      drop_held();
    end
  endtask

  task automatic predict_literal(input in_item_t it);
    int done_at;
    bit valid;
    out_item_t r;
    lit_q.delete();
    done_at = -1;
    valid = 1'b0;
    if (it.empty_string) begin
      drop_held();
      put_byte(QuoteChar);
      put_byte(QuoteChar);
      done_at = 1;
      valid = 1'b1;
      str_ok = 1'b1;
    end else begin
      if (it.first_byte) begin
        drop_held();
        str_ok = 1'b1;
        put_byte(QuoteChar);
      end
      feed_byte(it.data_byte);
      if (it.last_byte) begin
        flush_held();
        put_byte(QuoteChar);
        done_at = lit_q.size() - 1;
        valid = str_ok;
        str_ok = 1'b1;
        drop_held();
      end
    end
    for (int k = 0; k < lit_q.size(); k++) begin
      r.out_byte = lit_q[k];
      r.run_last = (k == lit_q.size() - 1);
      r.string_done = (k == done_at);
      r.string_valid = (k == done_at) && valid;
      json_out_q.insert(json_out_q.size(), r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i <= '0;
      drop_held();
      str_ok = 1'b1;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_literal(in_i);
        n_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0 && !rx_hold) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (feed_q.size() > 0 && !(feed_q[0].drain && json_out_q.size() > 0)) begin
          in_i <= feed_q[0].item;
          in_valid_i <= 1'b1;
          void'(feed_q.pop_front());
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (json_out_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MaxReports)
            $display("unexpected output byte %h last %b done %b valid %b", out_o.out_byte,
                     out_o.run_last, out_o.string_done, out_o.string_valid);
        end else begin
          if (out_o.out_byte !== json_out_q[0].out_byte ||
              out_o.run_last !== json_out_q[0].run_last ||
              out_o.string_done !== json_out_q[0].string_done ||
              out_o.string_valid !== json_out_q[0].string_valid) begin
            n_errors++;
            if (n_errors <= MaxReports)
              $display("mismatch: got byte %h last %b done %b valid %b, expected %h %b %b %b",
                       out_o.out_byte, out_o.run_last, out_o.string_done, out_o.string_valid,
                       json_out_q[0].out_byte, json_out_q[0].run_last,
                       json_out_q[0].string_done, json_out_q[0].string_valid);
          end
          void'(json_out_q.pop_front());
        end
      end
      rx_tick++;
      if (rx_hold) begin
        out_ready_i <= 1'b0;
      end else begin
        case ((rx_tick / 97) % 4)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= 1'($urandom_range(0, 1));
          2:       out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (rx_tick % 8 != 5);
        endcase
      end
    end
  end

  task automatic add_item(input logic [7:0] data, input bit first, input bit last,
                          input bit empty, input bit drain);
    feed_t f;
    f.item.data_byte = data;
    f.item.first_byte = first;
    f.item.last_byte = last;
    f.item.empty_string = empty;
    f.drain = drain;
    feed_q.insert(feed_q.size(), f);
  endtask

  task automatic add_string(input bit drain);
    for (int i = 0; i < str_q.size(); i++)
      add_item(str_q[i], i == 0, i == str_q.size() - 1, 1'b0, drain && i == 0);
  endtask

  task automatic put_utf8(input logic [20:0] cp, input int unsigned len);
    case (len)
      2: begin
        add_raw({3'b110, cp[10:6]});
        add_raw({2'b10, cp[5:0]});
      end
      3: begin
        add_raw({4'b1110, cp[15:12]});
        add_raw({2'b10, cp[11:6]});
        add_raw({2'b10, cp[5:0]});
      end
      default: begin
        add_raw({5'b11110, cp[20:18]});
        add_raw({2'b10, cp[17:12]});
        add_raw({2'b10, cp[11:6]});
        add_raw({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic add_random_unit();
    int unsigned r;
    int unsigned len;
    logic [20:0] cp;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      add_raw(8'($urandom_range(8'h20, 8'h7E)));
    end else if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       add_raw(QuoteChar);
        1:       add_raw(BackslashChar);
        default: add_raw(8'($urandom_range(0, 31)));
      endcase
    end else if (r < 80) begin
      len = $urandom_range(2, 4);
      case (len)
        2: cp = 21'($urandom_range('h80, 'h7FF));
        3: begin
          cp = 21'($urandom_range('h800, 'hFFFF));
          if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp - 21'h800;
        end
        default: cp = 21'($urandom_range('h10000, 'h10FFFF));
      endcase
      put_utf8(cp, len);
    end else if (r < 90) begin
      case ($urandom_range(0, 3))
        0: begin
          len = $urandom_range(2, 4);
          cp = 21'($urandom_range(0, (len == 2) ? 'h7F : (len == 3) ? 'h7FF : 'hFFFF));
          put_utf8(cp, len);
        end
        1: put_utf8(21'($urandom_range('hD800, 'hDFFF)), 3);
        2: put_utf8(21'($urandom_range('h110000, 'h1FFFFF)), 4);
        default: begin
          len = $urandom_range(2, 4);
          put_utf8(21'($urandom_range(0, 'h1FFFFF)), len);
          repeat ($urandom_range(1, len - 1)) void'(str_q.pop_back());
        end
      endcase
    end else begin
      add_raw(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic add_random_string(input bit drain);
    bit first;
    bit last;
    str_q.delete();
    repeat ($urandom_range(0, 6)) add_random_unit();
    if (str_q.size() == 0) begin
      add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 1'b1, drain);
    end else begin
      for (int i = 0; i < str_q.size(); i++) begin
        first = (i == 0) ? ($urandom_range(0, 11) != 0) : ($urandom_range(0, 40) == 0);
        last = (i == str_q.size() - 1) && ($urandom_range(0, 14) != 0);
        add_item(str_q[i], first, last, 1'b0, drain && i == 0);
      end
    end
  endtask

  initial begin
    int unsigned n_rand;
    int unsigned n_strings;
    int unsigned q_mark;

    add_item(8'hA5, 1'b1, 1'b1, 1'b1, 1'b0);
    str_q = '{8'h00, 8'h22, 8'h5C, 8'h08, 8'h0C, 8'h0A, 8'h0D, 8'h09};
    add_string(1'b0);
    str_q = '{8'hF0, 8'h9F, 8'h98, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hC0, 8'h80,
              8'hE2, 8'h41, 8'hF4, 8'h90, 8'h80, 8'h80};
    add_string(1'b0);
    add_item(8'hE2, 1'b1, 1'b0, 1'b0, 1'b0);
    add_item(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0);
    add_item(8'h80, 1'b0, 1'b0, 1'b0, 1'b0);
    add_item(8'hC3, 1'b0, 1'b1, 1'b0, 1'b0);
    add_item(8'hE2, 1'b1, 1'b0, 1'b0, 1'b0);
    add_item(8'h00, 1'b0, 1'b0, 1'b1, 1'b0);
    add_item(8'h41, 1'b0, 1'b0, 1'b0, 1'b0);
    add_item(8'h7F, 1'b0, 1'b1, 1'b0, 1'b0);

    n_rand = 0;
    n_strings = 0;
    while (n_rand < RandomItems) begin
      q_mark = feed_q.size();
      add_random_string(n_strings % 9 == 0);
      n_rand += feed_q.size() - q_mark;
      n_strings++;
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (feed_q.size() > 0 || in_valid_i) @(posedge clk_i);
    while (json_out_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (json_out_q.size() != 0) n_errors++;

    if (n_errors == 0) begin
      $display("json_string_escape_utf8_check verification clean");
    end else begin
      $display("json_string_escape_utf8_check verification failed");
    end
    $finish;
  end

  initial begin
    while (n_accepted < 60) @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #3_000_000;
    $display("json_string_escape_utf8_check verification failed");
    $finish;
  end

endmodule

[files.f]
hw/rtl/jsesc_pkg.sv
hw/rtl/jsesc_front.sv
hw/rtl/jsesc_fifo.sv
hw/rtl/jsesc_back.sv
hw/rtl/json_string_escape_utf8_check.sv
bench/tb.sv
